[hw/rtl/tsgd_pkg.sv]
// ----------------------------------------------------------------------------
// tsgd_pkg - shared definitions for the touch swipe gesture detector
// Register map, reset values, swipe codes and the types passed between the
// configuration block, the tracker and the top level.
// ----------------------------------------------------------------------------
package tsgd_pkg;

	// default widths of the datapath
	localparam int COORD_BITS_DEF = 12;
	localparam int TIME_BITS_DEF  = 32;

	// fixed register widths
	localparam int INTERVAL_W = 20;
	localparam int PIXEL_W    = 12;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GUARD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MIN_DX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_LEAD       = 3'd4;

	// register reset values
	localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST = 20'd20000;
	localparam logic [INTERVAL_W-1:0] RELEASE_GUARD_RST   = 20'd140000;
	localparam logic [PIXEL_W-1:0]    SWIPE_MIN_DX_RST    = 12'd32;
	localparam logic [PIXEL_W-1:0]    AXIS_LEAD_RST       = 12'd10;

	// swipe codes
	localparam logic [1:0] SWIPE_NONE  = 2'd0;
	localparam logic [1:0] SWIPE_LEFT  = 2'd1;
	localparam logic [1:0] SWIPE_RIGHT = 2'd2;

	typedef struct packed {
		logic                  device_enable;
		logic [INTERVAL_W-1:0] sample_interval;
		logic [INTERVAL_W-1:0] release_guard;
		logic [PIXEL_W-1:0]    swipe_min_dx;
		logic [PIXEL_W-1:0]    axis_lead;
	} cfg_t;

	typedef struct packed {
		logic touch_on;
		logic swipe_done;
		logic suppress;
	} trk_status_t;

endpackage

[hw/rtl/tsgd_if.sv]
// ----------------------------------------------------------------------------
// tsgd_if - item channels of the touch swipe gesture detector
// Poll channel (timestamp and touch sample) and pointer channel (pointer
// state, position and swipe code), both valid/ready.
// ----------------------------------------------------------------------------
interface tsgd_poll_if #(
	parameter int COORD_BITS = tsgd_pkg::COORD_BITS_DEF,
	parameter int TIME_BITS  = tsgd_pkg::TIME_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [TIME_BITS-1:0]  now_time;
	logic                  read_ok;
	logic                  touch_down;
	logic [COORD_BITS-1:0] touch_x;
	logic [COORD_BITS-1:0] touch_y;

	modport source (output valid, now_time, read_ok, touch_down, touch_x, touch_y,
		input ready);
	modport sink (input valid, now_time, read_ok, touch_down, touch_x, touch_y,
		output ready);
endinterface

interface tsgd_ptr_if #(
	parameter int COORD_BITS = tsgd_pkg::COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  pointer_pressed;
	logic [COORD_BITS-1:0] pointer_x;
	logic [COORD_BITS-1:0] pointer_y;
	logic [1:0]            swipe_code;

	modport source (output valid, pointer_pressed, pointer_x, pointer_y, swipe_code,
		input ready);
	modport sink (input valid, pointer_pressed, pointer_x, pointer_y, swipe_code,
		output ready);
endinterface

[hw/rtl/tsgd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tsgd_cfg_regs - configuration registers
// Write-only register file, one register per mapped index, reset to defaults.
// ----------------------------------------------------------------------------
module tsgd_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [tsgd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsgd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output tsgd_pkg::cfg_t                   cfg
);

	tsgd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_enable   <= 1'b0;
			cfg_q.sample_interval <= tsgd_pkg::SAMPLE_INTERVAL_RST;
			cfg_q.release_guard   <= tsgd_pkg::RELEASE_GUARD_RST;
			cfg_q.swipe_min_dx    <= tsgd_pkg::SWIPE_MIN_DX_RST;
			cfg_q.axis_lead       <= tsgd_pkg::AXIS_LEAD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tsgd_pkg::REG_DEVICE_ENABLE: begin
					cfg_q.device_enable <= cfg_data[0];
				end
				tsgd_pkg::REG_SAMPLE_INTERVAL: begin
					cfg_q.sample_interval <= cfg_data[tsgd_pkg::INTERVAL_W-1:0];
				end
				tsgd_pkg::REG_RELEASE_GUARD: begin
					cfg_q.release_guard <= cfg_data[tsgd_pkg::INTERVAL_W-1:0];
				end
				tsgd_pkg::REG_SWIPE_MIN_DX: begin
					cfg_q.swipe_min_dx <= cfg_data[tsgd_pkg::PIXEL_W-1:0];
				end
				tsgd_pkg::REG_AXIS_LEAD: begin
					cfg_q.axis_lead <= cfg_data[tsgd_pkg::PIXEL_W-1:0];
				end
				default: begin
					// unmapped index: write ignored
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/tsgd_tracker.sv]
// ----------------------------------------------------------------------------
// tsgd_tracker - touch state and swipe classification
// Holds the latched sample and touch tracking state; from one registered poll
// item works out the pointer result and the next state in a single pass.
// ----------------------------------------------------------------------------
module tsgd_tracker #(
	parameter int COORD_BITS = tsgd_pkg::COORD_BITS_DEF,
	parameter int TIME_BITS  = tsgd_pkg::TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsgd_pkg::cfg_t        cfg,
	input  logic                  step,
	input  logic [TIME_BITS-1:0]  now_time,
	input  logic                  read_ok,
	input  logic                  touch_down,
	input  logic [COORD_BITS-1:0] touch_x,
	input  logic [COORD_BITS-1:0] touch_y,
	output logic                  pointer_pressed,
	output logic [COORD_BITS-1:0] pointer_x,
	output logic [COORD_BITS-1:0] pointer_y,
	output logic [1:0]            swipe_code,
	output tsgd_pkg::trk_status_t status
);

	// travel compare width: wide enough for vertical travel plus margin
	localparam int SUM_W =
		((COORD_BITS > tsgd_pkg::PIXEL_W) ? COORD_BITS : tsgd_pkg::PIXEL_W) + 1;

	logic                  held_down_q, held_down_nx;
	logic [COORD_BITS-1:0] held_x_q, held_x_nx, held_y_q, held_y_nx;
	logic [COORD_BITS-1:0] last_x_q, last_x_nx, last_y_q, last_y_nx;
	logic [COORD_BITS-1:0] start_x_q, start_x_nx, start_y_q, start_y_nx;
	logic                  touch_on_q, touch_on_nx;
	logic                  swipe_done_q, swipe_done_nx;
	logic                  suppress_q, suppress_nx;
	logic [TIME_BITS-1:0]  press_time_q, press_time_nx;
	logic [TIME_BITS-1:0]  sample_time_q, sample_time_nx;

	logic [TIME_BITS-1:0]  since_sample, since_press;
	logic                  sample_due, guard_over;

	logic [COORD_BITS-1:0] cls_x, cls_y, ax, ay;
	logic                  cls_hit;
	logic [1:0]            cls_code;

	assign since_sample = now_time - sample_time_q;
	assign since_press  = now_time - press_time_q;
	assign sample_due   = since_sample >= TIME_BITS'(cfg.sample_interval);
	assign guard_over   = since_press >= TIME_BITS'(cfg.release_guard);

	// one classifier: latched sample during the touch, last position at release
	always_comb begin
		cls_x = held_down_nx ? held_x_nx : last_x_q;
		cls_y = held_down_nx ? held_y_nx : last_y_q;
		ax = (cls_x >= start_x_q) ? cls_x - start_x_q : start_x_q - cls_x;
		ay = (cls_y >= start_y_q) ? cls_y - start_y_q : start_y_q - cls_y;
		cls_hit = (SUM_W'(ax) >= SUM_W'(cfg.swipe_min_dx)) &&
			(SUM_W'(ax) > SUM_W'(ay) + SUM_W'(cfg.axis_lead));
		if (!cls_hit) begin
			cls_code = tsgd_pkg::SWIPE_NONE;
		end else if (cls_x < start_x_q) begin
			cls_code = tsgd_pkg::SWIPE_LEFT;
		end else begin
			cls_code = tsgd_pkg::SWIPE_RIGHT;
		end
	end

	always_comb begin
		held_down_nx   = held_down_q;
		held_x_nx      = held_x_q;
		held_y_nx      = held_y_q;
		last_x_nx      = last_x_q;
		last_y_nx      = last_y_q;
		start_x_nx     = start_x_q;
		start_y_nx     = start_y_q;
		touch_on_nx    = touch_on_q;
		swipe_done_nx  = swipe_done_q;
		suppress_nx    = suppress_q;
		press_time_nx  = press_time_q;
		sample_time_nx = sample_time_q;
		pointer_pressed = 1'b0;
		swipe_code      = tsgd_pkg::SWIPE_NONE;

		if (cfg.device_enable) begin
			if (sample_due) begin
				if (read_ok) begin
					held_down_nx = touch_down;
					held_x_nx    = touch_x;
					held_y_nx    = touch_y;
				end
				sample_time_nx = now_time;
			end

			if (suppress_q) begin
				// held released after a swipe until lift and guard expiry
				if (!held_down_nx && guard_over) begin
					suppress_nx   = 1'b0;
					touch_on_nx   = 1'b0;
					swipe_done_nx = 1'b0;
				end
			end else if (held_down_nx) begin
				pointer_pressed = 1'b1;
				last_x_nx       = held_x_nx;
				last_y_nx       = held_y_nx;
				press_time_nx   = now_time;
				if (!touch_on_q) begin
					touch_on_nx   = 1'b1;
					swipe_done_nx = 1'b0;
					start_x_nx    = held_x_nx;
					start_y_nx    = held_y_nx;
				end else if (!swipe_done_q) begin
					swipe_code = cls_code;
					if (cls_code != tsgd_pkg::SWIPE_NONE) begin
						swipe_done_nx   = 1'b1;
						suppress_nx     = 1'b1;
						pointer_pressed = 1'b0;
					end
				end
			end else if (touch_on_q && !guard_over) begin
				pointer_pressed = 1'b1;
			end else begin
				// touch ends: late swipe check on the last position
				if (touch_on_q && !swipe_done_q) begin
					swipe_code = cls_code;
				end
				touch_on_nx   = 1'b0;
				swipe_done_nx = 1'b0;
			end
		end
	end

	assign pointer_x = last_x_nx;
	assign pointer_y = last_y_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_down_q   <= 1'b0;
			held_x_q      <= '0;
			held_y_q      <= '0;
			last_x_q      <= '0;
			last_y_q      <= '0;
			start_x_q     <= '0;
			start_y_q     <= '0;
			touch_on_q    <= 1'b0;
			swipe_done_q  <= 1'b0;
			suppress_q    <= 1'b0;
			press_time_q  <= '0;
			sample_time_q <= '0;
		end else if (step) begin
			held_down_q   <= held_down_nx;
			held_x_q      <= held_x_nx;
			held_y_q      <= held_y_nx;
			last_x_q      <= last_x_nx;
			last_y_q      <= last_y_nx;
			start_x_q     <= start_x_nx;
			start_y_q     <= start_y_nx;
			touch_on_q    <= touch_on_nx;
			swipe_done_q  <= swipe_done_nx;
			suppress_q    <= suppress_nx;
			press_time_q  <= press_time_nx;
			sample_time_q <= sample_time_nx;
		end
	end

	assign status.touch_on   = touch_on_q;
	assign status.swipe_done = swipe_done_q;
	assign status.suppress   = suppress_q;

endmodule

[hw/rtl/touch_swipe_gesture_detector.sv]
// ----------------------------------------------------------------------------
// touch_swipe_gesture_detector - pointer state and horizontal swipe detection
// Turns polled touch samples into pointer items with a swipe code.
// ----------------------------------------------------------------------------
// Usage:
//   poll : one item per controller poll (timestamp, read status, touch
//          sample). Accepted on valid && ready.
//   ptr  : exactly one item per poll item, in order: pointer pressed,
//          last pressed position and swipe code (none, left, right).
//   cfg  : write-only registers, indexed as the register map in tsgd_pkg;
//          write only while no poll item is in flight.
// A poll item passes through the input register, then through the tracker
// into the result register, which drives ptr.
// Throughput is one item per cycle while ptr does not stall; the tracker state
// updates as each item advances, so back-to-back items see each other's updates.
// Reset clears both stages, all tracking state and restores the register
// defaults (controller disabled).
// When ptr stalls the result is held in the output register, the input
// register takes one more item, then poll.ready drops until ptr drains.
// ----------------------------------------------------------------------------
module touch_swipe_gesture_detector #(
	parameter int COORD_BITS = tsgd_pkg::COORD_BITS_DEF,
	parameter int TIME_BITS  = tsgd_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tsgd_poll_if.sink                       poll,
	tsgd_ptr_if.source                      ptr,
	input  logic                            cfg_wr_en,
	input  logic [tsgd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsgd_pkg::CFG_DATA_W-1:0] cfg_data
);

	tsgd_pkg::cfg_t        cfg;
	tsgd_pkg::trk_status_t trk_status;

	// input register
	logic                  valid_s1;
	logic [TIME_BITS-1:0]  now_time_s1;
	logic                  read_ok_s1;
	logic                  touch_down_s1;
	logic [COORD_BITS-1:0] touch_x_s1;
	logic [COORD_BITS-1:0] touch_y_s1;

	// result register
	logic                  valid_s2;
	logic                  pressed_s2;
	logic [COORD_BITS-1:0] x_s2;
	logic [COORD_BITS-1:0] y_s2;
	logic [1:0]            swipe_s2;

	// tracker result for the item in the input register
	logic                  trk_pressed;
	logic [COORD_BITS-1:0] trk_x;
	logic [COORD_BITS-1:0] trk_y;
	logic [1:0]            trk_swipe;

	logic advance;   // item moves from input register into result register
	logic in_take;

	assign advance    = valid_s1 && (!valid_s2 || ptr.ready);
	assign poll.ready = !valid_s1 || advance;
	assign in_take    = poll.valid && poll.ready;

	tsgd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsgd_tracker #(
		.COORD_BITS (COORD_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_tracker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.step            (advance),
		.now_time        (now_time_s1),
		.read_ok         (read_ok_s1),
		.touch_down      (touch_down_s1),
		.touch_x         (touch_x_s1),
		.touch_y         (touch_y_s1),
		.pointer_pressed (trk_pressed),
		.pointer_x       (trk_x),
		.pointer_y       (trk_y),
		.swipe_code      (trk_swipe),
		.status          (trk_status)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			now_time_s1   <= poll.now_time;
			read_ok_s1    <= poll.read_ok;
			touch_down_s1 <= poll.touch_down;
			touch_x_s1    <= poll.touch_x;
			touch_y_s1    <= poll.touch_y;
		end
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (ptr.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (advance) begin
			pressed_s2 <= trk_pressed;
			x_s2       <= trk_x;
			y_s2       <= trk_y;
			swipe_s2   <= trk_swipe;
		end
	end

	assign ptr.valid           = valid_s2;
	assign ptr.pointer_pressed = pressed_s2;
	assign ptr.pointer_x       = x_s2;
	assign ptr.pointer_y       = y_s2;
	assign ptr.swipe_code      = swipe_s2;

	// a reported swipe always comes with a released pointer
	a_swipe_released: assert property (@(posedge clk) disable iff (!arst_n)
		ptr.valid && (ptr.swipe_code != tsgd_pkg::SWIPE_NONE) |-> !ptr.pointer_pressed)
		else $error("swipe reported with pointer pressed");

	// a ready receiver never back-pressures the poll side
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		ptr.ready |-> poll.ready)
		else $error("poll stalled while ptr ready");

	// suppression only exists inside a touch that has already swiped
	a_suppress_in_touch: assert property (@(posedge clk) disable iff (!arst_n)
		trk_status.suppress |-> (trk_status.touch_on && trk_status.swipe_done))
		else $error("suppression outside a swiped touch");

	// a result enters the output register only when an item advances into it
	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(advance))
		else $error("result valid without an item advancing");

endmodule
